/* rtl/rtbe_pkg.sv */
// ----------------------------------------------------------------------------
// rtbe_pkg
// Types, widths and helpers for the Rice / truncated binary encoder.
// ----------------------------------------------------------------------------
package rtbe_pkg;

    localparam int VALUE_BITS   = 10;
    localparam int SEGMENT_BITS = 32;
    localparam int MAX_RICE_K   = 15;
    localparam int RICE_K_W     = 4;
    localparam int SEG_LEN_W    = 6;
    localparam int TOTAL_W      = 11;
    localparam int N_W          = VALUE_BITS + 1;
    localparam int LG_W         = $clog2(N_W);

    typedef struct packed {
        logic                  req_type;
        logic [VALUE_BITS-1:0] code_value;
        logic [RICE_K_W-1:0]   rice_k;
        logic [VALUE_BITS-1:0] max_value;
    } rtbe_req_t;

    typedef struct packed {
        logic [SEGMENT_BITS-1:0] code_bits;
        logic [SEG_LEN_W-1:0]    segment_length;
        logic [TOTAL_W-1:0]      total_length;
        logic                    is_last;
        logic                    value_error;
    } rtbe_seg_t;

    localparam logic REQ_RICE = 1'b0;
    localparam logic REQ_TBIN = 1'b1;

    // floor(log2(n)) for n >= 1
    function automatic logic [LG_W-1:0] floor_log2(input logic [N_W-1:0] n);
        logic [LG_W-1:0] lg;
        lg = '0;
        for (int i = 0; i < N_W; i++)
        begin
            if (n[i])
            begin
                lg = LG_W'(i);
            end
        end
        return lg;
    endfunction

endpackage

/* rtl/rice_and_truncated_binary_encoder.sv */
// ----------------------------------------------------------------------------
// rice_and_truncated_binary_encoder
// Forms a Rice or truncated binary code word and sends it MSB first in
// right-aligned segments, one segment per cycle unless seg_stall holds a valid output.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  req      | in  | req_valid/req_stall  | rtbe_req_t (type, value, k, max)
//  seg      | out | seg_valid/seg_stall  | rtbe_seg_t (bits, lengths, flags)
//
//  A transaction is latched in ST_IDLE, prepared in ST_SETUP, then sent as
//  segments from ST_EMIT; an error or an empty code word sends a single
//  segment.
//  The segment loop reuses one shift/merge unit; req_stall is high until the
//  last segment is loaded into the output register.
//  seg_stall holds a valid output register and pauses the segment loop.
//  rst_n clears the state and loop registers, not req_reg or out_reg.
// ----------------------------------------------------------------------------
module rice_and_truncated_binary_encoder
    import rtbe_pkg::*;
#(
    parameter int MAX_K = MAX_RICE_K
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  rtbe_req_t req,
    output logic      seg_valid,
    input  logic      seg_stall,
    output rtbe_seg_t seg
);

    localparam int K_W    = $clog2(MAX_K + 1);
    localparam int REST_W = (MAX_K + 1 > N_W) ? MAX_K + 1 : N_W;
    localparam int RL_W   = $clog2(REST_W + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]            state_reg, state_next;
    rtbe_req_t             req_reg;
    logic                  err_reg, err_next;
    logic [VALUE_BITS-1:0] ones_reg, ones_next;
    logic [REST_W-1:0]     rest_reg, rest_next;
    logic [RL_W-1:0]       rest_len_reg, rest_len_next;
    logic [TOTAL_W-1:0]    remain_reg, remain_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    rtbe_seg_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  out_free;
    logic [K_W-1:0]        k_sat;
    logic [VALUE_BITS-1:0] k_mask;
    logic [N_W-1:0]        n_val;
    logic [LG_W-1:0]       lg;
    logic [N_W:0]          t_wide;
    logic [N_W-1:0]        t_val;
    logic [N_W-1:0]        v_ext;
    logic [SEG_LEN_W-1:0]  seg_len;
    logic [SEG_LEN_W-1:0]  n_ones;
    logic [SEG_LEN_W-1:0]  n_rest;
    logic [SEG_LEN_W-1:0]  rest_shift;
    logic [RL_W-1:0]       rest_len_new;
    logic [SEGMENT_BITS-1:0] ones_field;
    logic [REST_W-1:0]       rest_field;

    assign req_stall = (state_reg != ST_IDLE);
    assign seg_valid = out_valid_reg;
    assign seg       = out_reg;
    assign out_free  = !out_valid_reg || !seg_stall;

    // code parameters
    always_comb
    begin
        if (32'(req_reg.rice_k) > MAX_K)
        begin
            k_sat = K_W'(MAX_K);
        end
        else
        begin
            k_sat = K_W'(req_reg.rice_k);
        end
        k_mask = ~({VALUE_BITS{1'b1}} << k_sat);
        n_val  = N_W'(req_reg.max_value) + N_W'(1);
        lg     = floor_log2(n_val);
        t_wide = ((N_W + 1)'(1) << (lg + LG_W'(1))) - (N_W + 1)'(n_val);
        t_val  = t_wide[N_W-1:0];
        v_ext  = N_W'(req_reg.code_value);
    end

    // segment slice
    always_comb
    begin
        if (remain_reg >= TOTAL_W'(SEGMENT_BITS))
        begin
            seg_len = SEG_LEN_W'(SEGMENT_BITS);
        end
        else
        begin
            seg_len = SEG_LEN_W'(remain_reg);
        end
        if (TOTAL_W'(ones_reg) < TOTAL_W'(seg_len))
        begin
            n_ones = SEG_LEN_W'(ones_reg);
        end
        else
        begin
            n_ones = seg_len;
        end
        n_rest       = seg_len - n_ones;
        rest_shift   = SEG_LEN_W'(rest_len_reg) - n_rest;
        rest_len_new = rest_len_reg - RL_W'(n_rest);
        ones_field   = (~({SEGMENT_BITS{1'b1}} << n_ones)) << n_rest;
        rest_field   = rest_reg >> rest_shift;
    end

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        ones_next      = ones_reg;
        rest_next      = rest_reg;
        rest_len_next  = rest_len_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && seg_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_EMIT;
                err_next   = 1'b0;
                if (req_reg.req_type == REQ_RICE)
                begin
                    ones_next     = req_reg.code_value >> k_sat;
                    rest_next     = REST_W'(req_reg.code_value & k_mask);
                    rest_len_next = RL_W'(k_sat) + RL_W'(1);
                    total_next    = TOTAL_W'(req_reg.code_value >> k_sat)
                                    + TOTAL_W'(k_sat) + TOTAL_W'(1);
                end
                else
                begin
                    ones_next = '0;
                    err_next  = (req_reg.code_value > req_reg.max_value);
                    if (v_ext < t_val)
                    begin
                        rest_next     = REST_W'(v_ext);
                        rest_len_next = RL_W'(lg);
                        total_next    = TOTAL_W'(lg);
                    end
                    else
                    begin
                        rest_next     = REST_W'(v_ext + t_val);
                        rest_len_next = RL_W'(lg) + RL_W'(1);
                        total_next    = TOTAL_W'(lg) + TOTAL_W'(1);
                    end
                end
                remain_next = total_next;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        out_next.code_bits      = '0;
                        out_next.segment_length = '0;
                        out_next.total_length   = '0;
                        out_next.is_last        = 1'b1;
                        out_next.value_error    = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        out_next.code_bits      = ones_field
                                                  | SEGMENT_BITS'(rest_field);
                        out_next.segment_length = seg_len;
                        out_next.total_length   = total_reg;
                        out_next.is_last        = (remain_reg == TOTAL_W'(seg_len));
                        out_next.value_error    = 1'b0;
                        ones_next               = ones_reg - VALUE_BITS'(n_ones);
                        rest_len_next           = rest_len_new;
                        rest_next               = rest_reg
                                                  & ~({REST_W{1'b1}} << rest_len_new);
                        remain_next             = remain_reg - TOTAL_W'(seg_len);
                        if (remain_reg == TOTAL_W'(seg_len))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            ones_reg      <= '0;
            rest_reg      <= '0;
            rest_len_reg  <= '0;
            remain_reg    <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
            ones_reg      <= ones_next;
            rest_reg      <= rest_next;
            rest_len_reg  <= rest_len_next;
            remain_reg    <= remain_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        out_reg <= out_next;
    end

endmodule
